/* rtl/ace_pkg.sv */
`default_nettype none

package ace_pkg;

    localparam int unsigned BG_BASE_LOW  = 40;
    localparam int unsigned BG_BASE_HIGH = 92;
    localparam int unsigned FG_BASE_LOW  = 30;
    localparam int unsigned FG_BASE_HIGH = 82;
    localparam int unsigned DIGIT_ZERO   = 48;
    localparam int unsigned BRIGHT_FIRST = 8;

    localparam logic [7:0] ESC_CHAR     = 8'h1B;
    localparam logic [7:0] LBRACKET     = 8'h5B;
    localparam logic [7:0] SEMICOLON    = 8'h3B;
    localparam logic [7:0] SGR_FINAL    = 8'h6D;
    localparam logic [7:0] HOME_FINAL   = 8'h48;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic [7:0] DIGIT_BASE     = 8'(DIGIT_ZERO);
    localparam logic [7:0] BG_LOW_TENS    = 8'(DIGIT_ZERO + BG_BASE_LOW / 10);
    localparam logic [7:0] BG_HIGH_HUNDS  = 8'(DIGIT_ZERO + (BG_BASE_HIGH + BRIGHT_FIRST) / 100);
    localparam logic [7:0] BG_HIGH_TENS   =
        8'(DIGIT_ZERO + ((BG_BASE_HIGH + BRIGHT_FIRST) / 10) % 10);
    localparam logic [7:0] FG_LOW_TENS    = 8'(DIGIT_ZERO + FG_BASE_LOW / 10);
    localparam logic [7:0] FG_HIGH_TENS   =
        8'(DIGIT_ZERO + ((FG_BASE_HIGH + BRIGHT_FIRST) / 10) % 10);

    localparam logic [2:0] HDR_LAST = 3'd6;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_ESC,
        PH_LBR,
        PH_BG_HUNDS,
        PH_BG_TENS,
        PH_BG_ONES,
        PH_SEMI,
        PH_FG_TENS,
        PH_FG_ONES,
        PH_SGR_END,
        PH_CHAR,
        PH_NEWLINE
    } phase_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] fore_color;
        logic [3:0] back_color;
        logic       header;
        logic       bg_dif;
        logic       fg_dif;
        logic       row_end;
    } cmd_t;

    function automatic logic [7:0] header_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = ESC_CHAR;
            3'd1:    b = LBRACKET;
            3'd2:    b = HOME_FINAL;
            3'd3:    b = ESC_CHAR;
            3'd4:    b = LBRACKET;
            3'd5:    b = DIGIT_BASE;
            default: b = SGR_FINAL;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/ansi_color_cell_encoder_top.sv */
`default_nettype none

// Channel   Handshake             Payload
// in        in_valid / in_stall   cell_char, fore_color, back_color, frame_start, row_end
// out       out_valid / out_stall out_byte, last_byte
//
// The back end sends one byte per cycle unless the output stalls, and a request
// yields from 1 to 18 bytes. Requests that output only their character follow
// each other every cycle without stalls. A two-entry queue lets requests arrive while
// earlier bytes are still going out. Reset clears the remembered colors.
// An output stall holds the current byte, and a full queue stalls the input.

module ansi_color_cell_encoder_top
    import ace_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] cell_char,
    input  wire logic [3:0] fore_color,
    input  wire logic [3:0] back_color,
    input  wire logic       frame_start,
    input  wire logic       row_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_byte
);

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    ace_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_char  (cell_char),
        .fore_color (fore_color),
        .back_color (back_color),
        .frame_start(frame_start),
        .row_end    (row_end),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    ace_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .q_full  (q_full),
        .q_valid (q_valid),
        .head_cmd(head_cmd)
    );

    ace_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head_cmd (head_cmd),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte (out_byte),
        .last_byte(last_byte)
    );

endmodule

`default_nettype wire

/* rtl/ace_front.sv */
`default_nettype none

module ace_front
    import ace_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] cell_char,
    input  wire logic [3:0] fore_color,
    input  wire logic [3:0] back_color,
    input  wire logic       frame_start,
    input  wire logic       row_end,
    input  wire logic       q_full,
    output logic            push,
    output cmd_t            push_cmd
);

    logic [3:0] sent_fore_reg, sent_fore_next;
    logic [3:0] sent_back_reg, sent_back_next;
    logic       known_reg, known_next;
    logic       known_eff;
    logic       bg_dif;
    logic       fg_dif;

    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;
    assign known_eff = known_reg && !frame_start;
    assign bg_dif    = !known_eff || (back_color != sent_back_reg);
    assign fg_dif    = !known_eff || (fore_color != sent_fore_reg);

    always_comb
    begin
        push_cmd.cell_char  = cell_char;
        push_cmd.fore_color = fore_color;
        push_cmd.back_color = back_color;
        push_cmd.header     = frame_start;
        push_cmd.bg_dif     = bg_dif;
        push_cmd.fg_dif     = fg_dif;
        push_cmd.row_end    = row_end;

        sent_fore_next = sent_fore_reg;
        sent_back_next = sent_back_reg;
        known_next     = known_reg;
        if (push && (bg_dif || fg_dif))
        begin
            sent_fore_next = fore_color;
            sent_back_next = back_color;
            known_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_fore_reg <= '0;
            sent_back_reg <= '0;
            known_reg     <= 1'b0;
        end
        else
        begin
            sent_fore_reg <= sent_fore_next;
            sent_back_reg <= sent_back_next;
            known_reg     <= known_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ace_cmd_queue.sv */
`default_nettype none

module ace_cmd_queue
    import ace_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      q_full,
    output logic      q_valid,
    output cmd_t      head_cmd
);

    cmd_t       slot_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_full   = (count_reg == 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign head_cmd = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/ace_back.sv */
`default_nettype none

module ace_back
    import ace_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire cmd_t       head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last_byte
);

    phase_t     phase_reg, phase_next;
    phase_t     cur_phase;
    phase_t     step_phase;
    logic       active_reg, active_next;
    logic [2:0] hdr_cnt_reg, hdr_cnt_next;
    logic [2:0] cur_cnt;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       last_byte_reg, last_byte_next;
    logic       emit;
    logic       is_last;
    logic [7:0] cur_byte;
    logic       any_dif;

    assign any_dif   = head_cmd.bg_dif || head_cmd.fg_dif;
    assign emit      = q_valid && (!out_valid_reg || !out_stall);
    assign pop       = emit && is_last;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

    always_comb
    begin
        if (active_reg)
        begin
            cur_phase = phase_reg;
            cur_cnt   = hdr_cnt_reg;
        end
        else
        begin
            cur_cnt = 3'd0;
            if (head_cmd.header)
            begin
                cur_phase = PH_HDR;
            end
            else if (any_dif)
            begin
                cur_phase = PH_ESC;
            end
            else
            begin
                cur_phase = PH_CHAR;
            end
        end

        is_last    = 1'b0;
        step_phase = cur_phase;
        cur_byte   = head_cmd.cell_char;
        unique case (cur_phase)
            PH_HDR:
            begin
                cur_byte = header_byte(cur_cnt);
                if (cur_cnt != HDR_LAST)
                begin
                    step_phase = PH_HDR;
                end
                else if (any_dif)
                begin
                    step_phase = PH_ESC;
                end
                else
                begin
                    step_phase = PH_CHAR;
                end
            end
            PH_ESC:
            begin
                cur_byte   = ESC_CHAR;
                step_phase = PH_LBR;
            end
            PH_LBR:
            begin
                cur_byte = LBRACKET;
                if (!head_cmd.bg_dif)
                begin
                    step_phase = PH_FG_TENS;
                end
                else if (head_cmd.back_color[3])
                begin
                    step_phase = PH_BG_HUNDS;
                end
                else
                begin
                    step_phase = PH_BG_TENS;
                end
            end
            PH_BG_HUNDS:
            begin
                cur_byte   = BG_HIGH_HUNDS;
                step_phase = PH_BG_TENS;
            end
            PH_BG_TENS:
            begin
                cur_byte   = head_cmd.back_color[3] ? BG_HIGH_TENS : BG_LOW_TENS;
                step_phase = PH_BG_ONES;
            end
            PH_BG_ONES:
            begin
                cur_byte   = DIGIT_BASE + {5'd0, head_cmd.back_color[2:0]};
                step_phase = head_cmd.fg_dif ? PH_SEMI : PH_SGR_END;
            end
            PH_SEMI:
            begin
                cur_byte   = SEMICOLON;
                step_phase = PH_FG_TENS;
            end
            PH_FG_TENS:
            begin
                cur_byte   = head_cmd.fore_color[3] ? FG_HIGH_TENS : FG_LOW_TENS;
                step_phase = PH_FG_ONES;
            end
            PH_FG_ONES:
            begin
                cur_byte   = DIGIT_BASE + {5'd0, head_cmd.fore_color[2:0]};
                step_phase = PH_SGR_END;
            end
            PH_SGR_END:
            begin
                cur_byte   = SGR_FINAL;
                step_phase = PH_CHAR;
            end
            PH_CHAR:
            begin
                cur_byte   = head_cmd.cell_char;
                step_phase = PH_NEWLINE;
                is_last    = !head_cmd.row_end;
            end
            PH_NEWLINE:
            begin
                cur_byte = NEWLINE_CHAR;
                is_last  = 1'b1;
            end
            default:
            begin
                cur_byte = head_cmd.cell_char;
                is_last  = 1'b1;
            end
        endcase

        phase_next     = phase_reg;
        active_next    = active_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_byte_next = last_byte_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            last_byte_next = is_last;
            active_next    = !is_last;
            phase_next     = step_phase;
            hdr_cnt_next   = (cur_phase == PH_HDR) ? cur_cnt + 3'd1 : cur_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            active_reg    <= 1'b0;
            hdr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        last_byte_reg <= last_byte_next;
    end

endmodule

`default_nettype wire

/* test/sgr_stream_checker.sv */
`default_nettype none

module sgr_stream_checker
    import ace_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] cell_char,
    input  wire logic [3:0] fore_color,
    input  wire logic [3:0] back_color,
    input  wire logic       frame_start,
    input  wire logic       row_end,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       last_byte,
    output int              errors,
    output int              pending,
    output int              cells_seen,
    output int              bytes_seen
);

    typedef struct packed {
        logic [7:0] code;
        logic       tail;
    } stream_byte_t;

    stream_byte_t expected_bytes[$];
    stream_byte_t cell_bytes[$];

    logic [3:0] shown_fore;
    logic [3:0] shown_back;
    logic       colors_known;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= 40)
        begin
            $display("mismatch at %0t: %s, got %h, want %h (output byte %0d)",
                     $time, what, got, want, bytes_seen);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        cell_bytes.push_back('{code: b, tail: 1'b0});
    endtask

    task automatic push_decimal(input int unsigned v);
        if (v > 99)
        begin
            push_byte(8'(DIGIT_ZERO + (v / 100) % 10));
        end
        if (v > 9)
        begin
            push_byte(8'(DIGIT_ZERO + (v / 10) % 10));
        end
        push_byte(8'(DIGIT_ZERO + v % 10));
    endtask

    // The bytes of a request are worked out when the request is accepted.
    task automatic encode_cell(input logic [7:0] ch, input logic [3:0] fg,
                               input logic [3:0] bg, input logic fs, input logic re);
        logic bg_new;
        logic fg_new;
        cell_bytes.delete();
        if (fs)
        begin
            push_byte(ESC_CHAR);
            push_byte(LBRACKET);
            push_byte(HOME_FINAL);
            push_byte(ESC_CHAR);
            push_byte(LBRACKET);
            push_byte(DIGIT_BASE);
            push_byte(SGR_FINAL);
            colors_known = 1'b0;
        end
        bg_new = !colors_known || (bg != shown_back);
        fg_new = !colors_known || (fg != shown_fore);
        if (bg_new || fg_new)
        begin
            push_byte(ESC_CHAR);
            push_byte(LBRACKET);
            if (bg_new)
            begin
                push_decimal(bg + (bg < BRIGHT_FIRST ? BG_BASE_LOW : BG_BASE_HIGH));
                if (fg_new)
                begin
                    push_byte(SEMICOLON);
                end
            end
            if (fg_new)
            begin
                push_decimal(fg + (fg < BRIGHT_FIRST ? FG_BASE_LOW : FG_BASE_HIGH));
            end
            push_byte(SGR_FINAL);
            shown_back = bg;
            shown_fore = fg;
            colors_known = 1'b1;
        end
        push_byte(ch);
        if (re)
        begin
            push_byte(NEWLINE_CHAR);
        end
        cell_bytes[cell_bytes.size() - 1].tail = 1'b1;
        foreach (cell_bytes[i])
        begin
            expected_bytes.push_back(cell_bytes[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stream_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            shown_fore = 4'd0;
            shown_back = 4'd0;
            colors_known = 1'b0;
            errors = 0;
            pending = 0;
            cells_seen = 0;
            bytes_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cells_seen++;
                encode_cell(cell_char, fore_color, back_color, frame_start, row_end);
            end
            if (out_valid && !out_stall)
            begin
                bytes_seen++;
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("byte with no request waiting", out_byte, 8'h00);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.code)
                    begin
                        report_mismatch("out_byte", out_byte, want.code);
                    end
                    if (last_byte !== want.tail)
                    begin
                        report_mismatch("last_byte", 8'(last_byte), 8'(want.tail));
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

`default_nettype wire

/* test/ansi_color_cell_encoder_top_test.sv */
`default_nettype none

module ansi_color_cell_encoder_top_test;
    import ace_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] cell_char = 8'd0;
    logic [3:0] fore_color = 4'd0;
    logic [3:0] back_color = 4'd0;
    logic       frame_start = 1'b0;
    logic       row_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last_byte;

    logic       in_fire = 1'b0;
    int         send_gap_pct = 0;
    int         stall_pct = 0;
    logic [3:0] prev_fore = 4'd0;
    logic [3:0] prev_back = 4'd0;

    int errors;
    int pending;
    int cells_seen;
    int bytes_seen;

    initial
    begin
        forever #4 clk = ~clk;
    end

    ansi_color_cell_encoder_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_char   (cell_char),
        .fore_color  (fore_color),
        .back_color  (back_color),
        .frame_start (frame_start),
        .row_end     (row_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    sgr_stream_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_char   (cell_char),
        .fore_color  (fore_color),
        .back_color  (back_color),
        .frame_start (frame_start),
        .row_end     (row_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_byte   (last_byte),
        .errors      (errors),
        .pending     (pending),
        .cells_seen  (cells_seen),
        .bytes_seen  (bytes_seen)
    );

    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_cell(input logic [7:0] ch, input logic [3:0] fg,
                             input logic [3:0] bg, input logic fs, input logic re);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cell_char   <= ch;
        fore_color  <= fg;
        back_color  <= bg;
        frame_start <= fs;
        row_end     <= re;
        in_valid    <= 1'b1;
        @(negedge clk);
        while (!in_fire)
        begin
            @(negedge clk);
        end
        prev_fore = fg;
        prev_back = bg;
    endtask

    task automatic random_cell();
        int unsigned pick;
        logic [3:0] fg;
        logic [3:0] bg;
        pick = $urandom_range(0, 9);
        fg = prev_fore;
        bg = prev_back;
        if (pick >= 5 && pick < 7)
        begin
            fg = 4'($urandom_range(0, 15));
        end
        else if (pick >= 7 && pick < 9)
        begin
            bg = 4'($urandom_range(0, 15));
        end
        else if (pick == 9)
        begin
            fg = 4'($urandom_range(0, 15));
            bg = 4'($urandom_range(0, 15));
        end
        send_cell(8'($urandom_range(0, 255)), fg, bg,
                  $urandom_range(0, 24) == 0, $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_cell(8'h00, 4'd0, 4'd0, 1'b0, 1'b0);
        send_cell(8'hFF, 4'd0, 4'd0, 1'b0, 1'b0);
        send_cell(8'hAA, 4'd15, 4'd0, 1'b0, 1'b0);
        send_cell(8'h55, 4'd15, 4'd15, 1'b0, 1'b0);
        send_cell(8'h41, 4'd8, 4'd8, 1'b0, 1'b0);
        send_cell(8'h42, 4'd8, 4'd8, 1'b1, 1'b1);
        send_cell(8'h00, 4'd7, 4'd7, 1'b1, 1'b0);
        send_cell(8'h0A, 4'd7, 4'd7, 1'b0, 1'b1);
        for (int i = 0; i < 16; i++)
        begin
            send_cell(8'(i * 17), 4'(i), 4'(15 - i), i == 0, i == 15);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            send_gap_pct = (phase == 1) ? 45 : (phase == 3) ? 19 : 0;
            stall_pct    = (phase == 2) ? 45 : (phase == 3) ? 19 : 0;
            repeat (120) random_cell();
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);

        $display("Encoded %0d cells into %0d terminal bytes,", cells_seen, bytes_seen);
        $display("with color changes, frame headers, row ends and four idle patterns.");
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #(8 * 400000);
        $display("Timed out with %0d output bytes still outstanding.", pending);
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/ace_pkg.sv
rtl/ace_front.sv
rtl/ace_cmd_queue.sv
rtl/ace_back.sv
rtl/ansi_color_cell_encoder_top.sv
test/sgr_stream_checker.sv
test/ansi_color_cell_encoder_top_test.sv
